// ===== hdl/onb_pkg.sv =====
// Shared types and constants for the Oren-Nayar diffuse reflectance block.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps
`default_nettype none

package onb_pkg;

    localparam int VEC_W    = 16;
    localparam int COEF_A_W = 17;
    localparam int COEF_B_W = 15;
    localparam int REFL_W   = 18;
    localparam int PDF_W    = 15;
    localparam int CFG_W    = 17;
    localparam int K_W      = 19;

    // 1/pi in Q0.20.
    localparam logic [K_W-1:0]      INV_PI_Q20   = 19'd333772;
    localparam logic [COEF_A_W-1:0] COEF_A_RESET = 17'd65536;
    localparam logic [COEF_B_W-1:0] COEF_B_RESET = 15'd0;
    localparam logic [REFL_W-1:0]   REFL_MAX     = 18'h3FFFF;
    localparam logic [PDF_W-1:0]    PDF_MAX      = 15'h7FFF;

    typedef enum logic [0:0] {
        REG_COEF_A = 1'b0,
        REG_COEF_B = 1'b1
    } cfg_reg_t;

    // Per-item flags and early results that ride alongside the divider.
    typedef struct packed {
        logic             tx;
        logic             dzero;
        logic             ovf;
        logic [PDF_W-1:0] pdf;
    } onb_side_t;

endpackage

`default_nettype wire

// ===== hdl/onb_ifs.sv =====
// Request and response channel interfaces for the Oren-Nayar block.
// Depends on onb_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface onb_req_if;
    logic                                valid;
    logic                                ready;
    logic signed [onb_pkg::VEC_W-1:0]    in_x;
    logic signed [onb_pkg::VEC_W-1:0]    in_y;
    logic signed [onb_pkg::VEC_W-1:0]    in_z;
    logic signed [onb_pkg::VEC_W-1:0]    nrm_x;
    logic signed [onb_pkg::VEC_W-1:0]    nrm_y;
    logic signed [onb_pkg::VEC_W-1:0]    nrm_z;
    logic signed [onb_pkg::VEC_W-1:0]    out_x;
    logic signed [onb_pkg::VEC_W-1:0]    out_y;
    logic signed [onb_pkg::VEC_W-1:0]    out_z;
    logic                                is_transmitted;

    modport source (output valid, in_x, in_y, in_z, nrm_x, nrm_y, nrm_z,
                    out_x, out_y, out_z, is_transmitted, input ready);
    modport sink (input valid, in_x, in_y, in_z, nrm_x, nrm_y, nrm_z,
                  out_x, out_y, out_z, is_transmitted, output ready);
endinterface

interface onb_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [onb_pkg::REFL_W-1:0]    reflectance;
    logic [onb_pkg::PDF_W-1:0]     pdf;
    logic                          saturated;

    modport source (output valid, reflectance, pdf, saturated, input ready);
    modport sink (input valid, reflectance, pdf, saturated, output ready);
endinterface

`default_nettype wire

// ===== hdl/onb_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on onb_pkg for the side-band struct carried with each request.
`timescale 1ns / 1ps
`default_nettype none

module onb_div #(
    parameter int RW = 21,
    parameter int QW = 41
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [RW-1:0]     in_d,
    input  wire logic [RW-1:0]     in_rem,
    input  wire logic [QW-1:0]     in_num,
    input  wire onb_pkg::onb_side_t in_side,
    output logic                   out_valid,
    output logic [QW-1:0]          out_quo,
    output onb_pkg::onb_side_t     out_side
);

    logic               v_reg    [0:QW-1];
    logic [RW-1:0]      rem_reg  [0:QW-1];
    logic [RW-1:0]      d_reg    [0:QW-1];
    logic [QW-1:0]      n_reg    [0:QW-1];
    logic [QW-1:0]      q_reg    [0:QW-1];
    onb_pkg::onb_side_t side_reg [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic               v_in;
        logic [RW-1:0]      r_in;
        logic [RW-1:0]      d_in;
        logic [QW-1:0]      n_in;
        logic [QW-1:0]      q_in;
        onb_pkg::onb_side_t s_in;
        logic [RW:0]        r2;
        logic               ge;

        if (k == 0) begin : g_first
            assign v_in = in_valid;
            assign r_in = in_rem;
            assign d_in = in_d;
            assign n_in = in_num;
            assign q_in = '0;
            assign s_in = in_side;
        end else begin : g_next
            assign v_in = v_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign d_in = d_reg[k-1];
            assign n_in = n_reg[k-1];
            assign q_in = q_reg[k-1];
            assign s_in = side_reg[k-1];
        end

        // The partial remainder stays below the divisor, so one subtract decides the bit.
        assign r2 = {r_in, n_in[QW-1]};
        assign ge = (r2 >= {1'b0, d_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= ge ? RW'(r2 - {1'b0, d_in}) : r2[RW-1:0];
                d_reg[k]    <= d_in;
                n_reg[k]    <= n_in << 1;
                q_reg[k]    <= {q_in[QW-2:0], ge};
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_quo   = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

`default_nettype wire

// ===== hdl/oren_nayar_diffuse_brdf.sv =====
// Oren-Nayar diffuse reflectance: one request accepted per cycle while the output is not held.
// Most of the pipeline depth is the long divider, which resolves
// one quotient bit per stage over 27 + VEC_FRAC_BITS stages.
// A single pipeline-wide advance stalls every stage when the output is held.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads A = 1.0, B = 0.
`timescale 1ns / 1ps
`default_nettype none

module oren_nayar_diffuse_brdf #(
    parameter int VEC_FRAC_BITS = 14,
    parameter int OUT_FRAC_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [0:0]                   cfg_index,
    input  wire logic [onb_pkg::CFG_W-1:0]    cfg_data,
    onb_req_if.sink                           req,
    onb_rsp_if.source                         rsp
);

    localparam int F   = VEC_FRAC_BITS;
    localparam int KW  = onb_pkg::K_W;
    localparam int BW  = onb_pkg::COEF_B_W;
    // Width of a rounded dot product, signed.
    localparam int RW  = 35 - F;
    // The numerator dot(in,out) - ci*co, signed, and its positive part g.
    localparam int NW  = ((RW + F) > 2 * RW ? (RW + F) : 2 * RW) + 1;
    localparam int GW  = NW - 1;
    localparam int GL  = 24;
    localparam int GH  = GW - GL;
    // Quotient bits: the B term is kept up to 2^11, which is saturated at any output scale.
    localparam int QW  = 27 + F;
    localparam int MW  = BW + GW;
    localparam int NX  = (MW > QW) ? MW : QW + 1;
    localparam int TW  = QW + 1;
    localparam int TF  = 16 + F;
    localparam int SL  = (TF < 32) ? 32 - TF : 0;
    localparam int SR  = (TF >= 32) ? TF - 32 : 0;
    localparam int EW  = (TW + SL > 43) ? TW + SL : 43;
    localparam int SH  = 52 - OUT_FRAC_BITS;
    localparam int PSL = 32 - F;

    // A squared sine passes when c^2 is below one minus the small-angle threshold.
    localparam logic [63:0] ONE_SQ = 64'd1 << (2 * F);
    localparam logic [63:0] SIN_LIM = ONE_SQ - (ONE_SQ / 64'd10000);
    localparam logic [63:0] RND = 64'd1 << (SH - 1);
    localparam logic [63:0] Q32_LIM = 64'd1 << 42;
    localparam logic [63:0] CAPQ = (Q32_LIM - 64'd1) * 64'd333772;
    localparam logic [63:0] PDF_CAP_CO = 64'd1 << (10 + F);

    // Round a three-term dot product to F fraction bits, ties away from zero.
    function automatic logic signed [RW-1:0] dot_round(input logic signed [31:0] a,
                                                       input logic signed [31:0] b,
                                                       input logic signed [31:0] c);
        logic signed [33:0] s;
        logic [33:0]        mag;
        logic [33:0]        m;
        s   = 34'(a) + 34'(b) + 34'(c);
        mag = s[33] ? 34'(-s) : 34'(s);
        m   = (mag + (34'd1 << (F - 1))) >> F;
        return s[33] ? RW'(-m) : RW'(m);
    endfunction

    // ------------------------------------------------------------------------
    // Configuration registers. User must write only while the pipeline is empty; unchecked.
    // ------------------------------------------------------------------------
    logic [onb_pkg::COEF_A_W-1:0] coef_a_reg;
    logic [BW-1:0]                coef_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= onb_pkg::COEF_A_RESET;
            coef_b_reg <= onb_pkg::COEF_B_RESET;
        end
        else if (cfg_we)
        begin
            unique case (onb_pkg::cfg_reg_t'(cfg_index))
                onb_pkg::REG_COEF_A: coef_a_reg <= cfg_data[onb_pkg::COEF_A_W-1:0];
                onb_pkg::REG_COEF_B: coef_b_reg <= cfg_data[BW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Flow control. Every stage moves together whenever the output register is
    // free or being emptied this cycle, so a held response stalls the lot and a
    // request is never dropped or duplicated.
    // ------------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;

    assign adv       = !out_valid_reg || rsp.ready;
    assign req.ready = adv;

    // Stage 1: the nine component products.
    logic              v1_reg, tx1_reg;
    logic signed [31:0] p1_reg [0:8];

    // Stage 2: rounded cosines ci, co and the in/out cosine.
    logic                 v2_reg, tx2_reg;
    logic signed [RW-1:0] ci2_reg, co2_reg, dio2_reg;

    // Stage 3: squares, cross product and the divisor max(|ci|,|co|).
    logic                   v3_reg, tx3_reg;
    logic [2*RW-1:0]        cisq3_reg, cosq3_reg;
    logic signed [2*RW-1:0] cico3_reg;
    logic signed [RW-1:0]   dio3_reg, co3_reg;
    logic [RW-1:0]          d3_reg;
    logic [RW-1:0]          aci_next, aco_next;

    // Stage 4: the gated numerator g, and the density product.
    logic                 v4_reg, tx4_reg, dzero4_reg, copos4_reg, pcap4_reg;
    logic [GW-1:0]        g4_reg;
    logic [RW-1:0]        d4_reg;
    logic [RW+KW-1:0]     pk4_reg;
    logic                 pass_next;
    logic signed [NW-1:0] num_next;
    logic [RW-1:0]        co_mag_next;

    // Stage 5: B times g in two halves, and the finished density.
    logic                v5_reg, tx5_reg, dzero5_reg;
    logic [BW+GL-1:0]    plo5_reg;
    logic [BW+GH-1:0]    phi5_reg;
    logic [RW-1:0]       d5_reg;
    logic [onb_pkg::PDF_W-1:0] pdf5_reg;
    logic [63:0]         pq_next;
    logic [63:0]         pr_next;
    logic [onb_pkg::PDF_W-1:0] pdf_next;

    // Stage 6: full dividend, overflow test and divider set-up.
    logic               v6_reg;
    logic [RW-1:0]      d6_reg, rem6_reg;
    logic [QW-1:0]      nlow6_reg;
    onb_pkg::onb_side_t side6_reg;
    logic [NX-1:0]      nfull_next;
    logic [NX-1:0]      ntop_next;

    always_comb
    begin
        aci_next    = ci2_reg[RW-1] ? RW'(-ci2_reg) : RW'(ci2_reg);
        aco_next    = co2_reg[RW-1] ? RW'(-co2_reg) : RW'(co2_reg);
        pass_next   = (64'(cisq3_reg) < SIN_LIM) && (64'(cosq3_reg) < SIN_LIM);
        num_next    = (NW'(dio3_reg) <<< F) - NW'(cico3_reg);
        co_mag_next = RW'(co3_reg);
        // Density: cosine taken to 32 fraction bits with the 2^42 cap, then times 1/pi.
        pq_next     = pcap4_reg ? CAPQ : (64'(pk4_reg) << PSL);
        pr_next     = (pq_next + RND) >> SH;
        if (!copos4_reg)
        begin
            pdf_next = '0;
        end
        else if (pr_next > 64'(onb_pkg::PDF_MAX))
        begin
            pdf_next = onb_pkg::PDF_MAX;
        end
        else
        begin
            pdf_next = pr_next[onb_pkg::PDF_W-1:0];
        end
        nfull_next = (NX'(phi5_reg) << GL) + NX'(plo5_reg);
        ntop_next  = nfull_next >> QW;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tx1_reg   <= req.is_transmitted;
            p1_reg[0] <= 32'(req.in_x) * 32'(req.nrm_x);
            p1_reg[1] <= 32'(req.in_y) * 32'(req.nrm_y);
            p1_reg[2] <= 32'(req.in_z) * 32'(req.nrm_z);
            p1_reg[3] <= 32'(req.out_x) * 32'(req.nrm_x);
            p1_reg[4] <= 32'(req.out_y) * 32'(req.nrm_y);
            p1_reg[5] <= 32'(req.out_z) * 32'(req.nrm_z);
            p1_reg[6] <= 32'(req.in_x) * 32'(req.out_x);
            p1_reg[7] <= 32'(req.in_y) * 32'(req.out_y);
            p1_reg[8] <= 32'(req.in_z) * 32'(req.out_z);

            tx2_reg  <= tx1_reg;
            ci2_reg  <= dot_round(p1_reg[0], p1_reg[1], p1_reg[2]);
            co2_reg  <= dot_round(p1_reg[3], p1_reg[4], p1_reg[5]);
            dio2_reg <= dot_round(p1_reg[6], p1_reg[7], p1_reg[8]);

            tx3_reg   <= tx2_reg;
            cisq3_reg <= (2*RW)'(ci2_reg) * (2*RW)'(ci2_reg);
            cosq3_reg <= (2*RW)'(co2_reg) * (2*RW)'(co2_reg);
            cico3_reg <= (2*RW)'(ci2_reg) * (2*RW)'(co2_reg);
            dio3_reg  <= dio2_reg;
            co3_reg   <= co2_reg;
            d3_reg    <= (aci_next > aco_next) ? aci_next : aco_next;

            tx4_reg    <= tx3_reg;
            g4_reg     <= (pass_next && !num_next[NW-1] && (num_next != '0))
                          ? num_next[GW-1:0] : '0;
            d4_reg     <= d3_reg;
            dzero4_reg <= (d3_reg == '0);
            copos4_reg <= !co3_reg[RW-1] && (co3_reg != '0);
            pcap4_reg  <= (64'(co3_reg) >= PDF_CAP_CO);
            pk4_reg    <= (RW+KW)'(co_mag_next) * (RW+KW)'(onb_pkg::INV_PI_Q20);

            tx5_reg    <= tx4_reg;
            dzero5_reg <= dzero4_reg;
            d5_reg     <= d4_reg;
            plo5_reg   <= (BW+GL)'(coef_b_reg) * (BW+GL)'(g4_reg[GL-1:0]);
            phi5_reg   <= (BW+GH)'(coef_b_reg) * (BW+GH)'(g4_reg[GW-1:GL]);
            pdf5_reg   <= pdf_next;

            d6_reg          <= d5_reg;
            rem6_reg        <= RW'(ntop_next);
            nlow6_reg       <= nfull_next[QW-1:0];
            side6_reg.tx    <= tx5_reg;
            side6_reg.dzero <= dzero5_reg;
            side6_reg.ovf   <= (ntop_next >= NX'(d5_reg));
            side6_reg.pdf   <= pdf5_reg;
        end
    end

    // ------------------------------------------------------------------------
    // floor(B*g / d), one quotient bit per stage.
    // ------------------------------------------------------------------------
    logic               v7;
    logic [QW-1:0]      q7;
    onb_pkg::onb_side_t side7;

    onb_div #(
        .RW (RW),
        .QW (QW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v6_reg),
        .in_d      (d6_reg),
        .in_rem    (rem6_reg),
        .in_num    (nlow6_reg),
        .in_side   (side6_reg),
        .out_valid (v7),
        .out_quo   (q7),
        .out_side  (side7)
    );

    // Stage 8: A + B term, brought to 32 fraction bits and capped below 2^42.
    // Stage 9: the capped value times 1/pi, split into two 21-bit halves.
    // Output stage: rounding, saturation and the special cases.
    logic               v8_reg, v9_reg;
    logic [41:0]        v42_8_reg;
    onb_pkg::onb_side_t side8_reg, side9_reg;
    logic [KW+20:0]     mlo9_reg, mhi9_reg;
    logic [QW-1:0]      qeff_next;
    logic [TW-1:0]      total_next;
    logic [EW-1:0]      ext_next;
    logic [63:0]        rq_next;
    logic [63:0]        rr_next;

    logic [onb_pkg::REFL_W-1:0] refl_reg, refl_next;
    logic [onb_pkg::PDF_W-1:0]  pdf_reg, pdf_out_next;
    logic                       sat_reg, sat_next;

    always_comb
    begin
        qeff_next  = side7.ovf ? '1 : q7;
        total_next = (TW'(coef_a_reg) << F) + TW'(qeff_next);
        ext_next   = (EW'(total_next) << SL) >> SR;
        rq_next    = (64'(mhi9_reg) << 21) + 64'(mlo9_reg);
        rr_next    = (rq_next + RND) >> SH;

        if (side9_reg.tx)
        begin
            refl_next    = '0;
            pdf_out_next = '0;
            sat_next     = 1'b0;
        end
        else if (side9_reg.dzero)
        begin
            refl_next    = onb_pkg::REFL_MAX;
            pdf_out_next = side9_reg.pdf;
            sat_next     = 1'b1;
        end
        else if (rr_next > 64'(onb_pkg::REFL_MAX))
        begin
            refl_next    = onb_pkg::REFL_MAX;
            pdf_out_next = side9_reg.pdf;
            sat_next     = 1'b1;
        end
        else
        begin
            refl_next    = rr_next[onb_pkg::REFL_W-1:0];
            pdf_out_next = side9_reg.pdf;
            sat_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v8_reg        <= v7;
            v9_reg        <= v8_reg;
            out_valid_reg <= v9_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side8_reg <= side7;
            v42_8_reg <= (ext_next >= EW'(Q32_LIM)) ? '1 : ext_next[41:0];

            side9_reg <= side8_reg;
            mlo9_reg  <= (KW+21)'(v42_8_reg[20:0]) * (KW+21)'(onb_pkg::INV_PI_Q20);
            mhi9_reg  <= (KW+21)'(v42_8_reg[41:21]) * (KW+21)'(onb_pkg::INV_PI_Q20);

            refl_reg <= refl_next;
            pdf_reg  <= pdf_out_next;
            sat_reg  <= sat_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.reflectance = refl_reg;
    assign rsp.pdf         = pdf_reg;
    assign rsp.saturated   = sat_reg;

endmodule

`default_nettype wire
